/* sv/trs_pkg.sv */
// ----------------------------------------------------------------------------
// TRS pose package
// Payload types and widths for the pose to affine matrix unit.
// ----------------------------------------------------------------------------
`default_nettype none
package trs_pkg;
    localparam int unsigned FracBitsDefault = 16;
    localparam int unsigned WordW = 32;

    typedef struct packed {
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
        logic signed [31:0] rot_x;
        logic signed [31:0] rot_y;
        logic signed [31:0] rot_z;
        logic signed [31:0] rot_w;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } t_pose;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m10;
        logic signed [31:0] m20;
        logic signed [31:0] m01;
        logic signed [31:0] m11;
        logic signed [31:0] m21;
        logic signed [31:0] m02;
        logic signed [31:0] m12;
        logic signed [31:0] m22;
        logic signed [31:0] m03;
        logic signed [31:0] m13;
        logic signed [31:0] m23;
    } t_affine;
endpackage
`default_nettype wire

/* sv/trs_pose_to_affine_matrix_unit.sv */
// ----------------------------------------------------------------------------
// Pose to affine matrix unit
// Normalizes a pose quaternion, builds the scaled rotation and emits the
// twelve entries of the translate*rotate*scale matrix.
// ----------------------------------------------------------------------------
// Pipeline: 4 front stages, 31 square root stages, FRAC_BITS + 31 divide
//   stages and 4 back stages; a stall holds every stage.
// Throughput: one pose per cycle; every stage has a valid bit and the whole
//   pipe advances when the output register is empty or being taken.
// Reset: synchronous, active low; clears all valid bits, payload not reset.
`default_nettype none
module trs_pose_to_affine_matrix_unit #(
    parameter int unsigned FRAC_BITS = trs_pkg::FracBitsDefault
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire trs_pkg::t_pose i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output trs_pkg::t_affine    o_data
);
    import trs_pkg::*;

    localparam int unsigned SqW   = 62;           // sum of four squares < 2^62
    localparam int unsigned SqSt  = 31;           // root bits
    localparam int unsigned QW    = 30 + FRAC_BITS + 1;
    localparam int unsigned DivSt = QW;
    localparam int unsigned UW    = FRAC_BITS + 2; // unit magnitude bits
    localparam int unsigned NS    = 4 + SqSt + DivSt + 4;

    // global stall: whole pipe advances together
    logic w_adv;
    assign w_adv = !o_valid || i_ready;
    assign o_ready = w_adv;

    logic [NS-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // common side data carried through every stage
    typedef struct packed {
        logic [3:0]         neg;
        logic               zero;
        logic signed [31:0] sx, sy, sz, tx, ty, tz;
    } t_side;

    // stage 0: magnitudes
    t_side       r_s0;
    logic [31:0] r_a0 [4];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0.neg  <= {i_data.rot_w[31], i_data.rot_z[31],
                          i_data.rot_y[31], i_data.rot_x[31]};
            r_s0.zero <= (i_data.rot_x == 0) && (i_data.rot_y == 0) &&
                         (i_data.rot_z == 0) && (i_data.rot_w == 0);
            r_s0.sx <= i_data.scale_x; r_s0.sy <= i_data.scale_y;
            r_s0.sz <= i_data.scale_z; r_s0.tx <= i_data.trans_x;
            r_s0.ty <= i_data.trans_y; r_s0.tz <= i_data.trans_z;
            r_a0[0] <= i_data.rot_x[31] ? 32'(-i_data.rot_x) : i_data.rot_x;
            r_a0[1] <= i_data.rot_y[31] ? 32'(-i_data.rot_y) : i_data.rot_y;
            r_a0[2] <= i_data.rot_z[31] ? 32'(-i_data.rot_z) : i_data.rot_z;
            r_a0[3] <= i_data.rot_w[31] ? 32'(-i_data.rot_w) : i_data.rot_w;
        end
    end

    // stage 1: leading-one position of the OR of magnitudes (same as of max)
    logic [31:0] w_or;
    logic [4:0]  w_lz;
    assign w_or = r_a0[0] | r_a0[1] | r_a0[2] | r_a0[3];
    always_comb begin
        w_lz = 5'd0;
        for (int k = 0; k < 32; k++) begin
            if (w_or[k]) w_lz = 5'(k);
        end
    end
    t_side       r_s1;
    logic [31:0] r_a1 [4];
    logic [4:0]  r_msb1;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1 <= r_s0; r_a1 <= r_a0; r_msb1 <= w_lz;
        end
    end

    // stage 2: align so the largest lies in [2^29, 2^30)
    t_side       r_s2;
    logic [29:0] r_a2 [4];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2 <= r_s1;
            for (int k = 0; k < 4; k++) begin
                if (r_msb1 >= 5'd29) begin
                    r_a2[k] <= 30'(r_a1[k] >> (r_msb1 - 5'd29));
                end else begin
                    r_a2[k] <= 30'(r_a1[k] << (5'd29 - r_msb1));
                end
            end
        end
    end

    // stage 3: sum of squares
    t_side         r_s3;
    logic [29:0]   r_a3 [4];
    logic [SqW-1:0] r_sum3;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3 <= r_s2; r_a3 <= r_a2;
            r_sum3 <= SqW'(64'(r_a2[0]) * r_a2[0] + 64'(r_a2[1]) * r_a2[1] +
                           64'(r_a2[2]) * r_a2[2] + 64'(r_a2[3]) * r_a2[3]);
        end
    end

    // square root, one result bit per stage (restoring)
    t_side          r_qs [SqSt+1];
    logic [29:0]    r_qa [SqSt+1][4];
    logic [SqW+1:0] r_rem [SqSt+1];
    logic [SqSt-1:0] r_root [SqSt+1];
    always_comb begin
        r_qs[0] = r_s3; r_qa[0] = r_a3;
        r_rem[0] = {2'b00, r_sum3}; r_root[0] = '0;
    end
    for (genvar g = 0; g < SqSt; g++) begin : g_sqrt
        logic [SqW+1:0] w_trial;
        logic [SqW+1:0] w_chunk;
        assign w_chunk = (r_rem[g] >> (2 * (SqSt - 1 - g)));
        assign w_trial = {(SqW+2-SqSt-2)'(0), r_root[g], 2'b01};
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_qs[g+1] <= r_qs[g]; r_qa[g+1] <= r_qa[g];
                if (w_chunk >= w_trial) begin
                    r_rem[g+1]  <= r_rem[g] - (w_trial << (2 * (SqSt - 1 - g)));
                    r_root[g+1] <= {r_root[g][SqSt-2:0], 1'b1};
                end else begin
                    r_rem[g+1]  <= r_rem[g];
                    r_root[g+1] <= {r_root[g][SqSt-2:0], 1'b0};
                end
            end
        end
    end

    // divide: (a << F) + L/2 over L, four lanes, one quotient bit per stage
    typedef logic [QW-1:0] t_q;
    t_side       r_ds  [DivSt+1];
    logic [30:0] r_len [DivSt+1];
    t_q          r_num [DivSt+1][4];
    logic [31:0] r_drem [DivSt+1][4];
    always_comb begin
        r_ds[0] = r_qs[SqSt]; r_len[0] = r_root[SqSt];
        for (int k = 0; k < 4; k++) begin
            r_num[0][k]  = t_q'({r_qa[SqSt][k], FRAC_BITS'(0)}) +
                           t_q'(r_root[SqSt] >> 1);
            r_drem[0][k] = '0;
        end
    end
    for (genvar g = 0; g < DivSt; g++) begin : g_div
        always_ff @(posedge i_clk) begin
            logic [32:0] t;
            if (w_adv) begin
                r_ds[g+1] <= r_ds[g]; r_len[g+1] <= r_len[g];
                for (int k = 0; k < 4; k++) begin
                    t = {r_drem[g][k], r_num[g][k][QW-1]};
                    if (t >= 33'(r_len[g])) begin
                        r_drem[g+1][k] <= 32'(t - 33'(r_len[g]));
                        r_num[g+1][k]  <= {r_num[g][k][QW-2:0], 1'b1};
                    end else begin
                        r_drem[g+1][k] <= 32'(t);
                        r_num[g+1][k]  <= {r_num[g][k][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // signed unit components, identity when the quaternion is zero
    logic signed [UW:0] w_u [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_u[k] = r_ds[DivSt].neg[k] ? -$signed({1'b0, UW'(r_num[DivSt][k])})
                                        :  $signed({1'b0, UW'(r_num[DivSt][k])});
            if (r_ds[DivSt].zero) w_u[k] = (k == 3) ? (UW+1)'(1 << FRAC_BITS) : '0;
        end
    end

    // stage P: products
    localparam int unsigned PW = 2 * UW + 4;
    function automatic logic signed [PW-1:0] pmul(input logic signed [UW:0] a,
                                                  input logic signed [UW:0] b);
        return PW'(a) * PW'(b);
    endfunction
    t_side r_ps;
    logic signed [PW-1:0] r_p [9];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ps <= r_ds[DivSt];
            r_p[0] <= pmul(w_u[0], w_u[0]); r_p[1] <= pmul(w_u[1], w_u[1]);
            r_p[2] <= pmul(w_u[2], w_u[2]); r_p[3] <= pmul(w_u[0], w_u[1]);
            r_p[4] <= pmul(w_u[0], w_u[2]); r_p[5] <= pmul(w_u[1], w_u[2]);
            r_p[6] <= pmul(w_u[3], w_u[0]); r_p[7] <= pmul(w_u[3], w_u[1]);
            r_p[8] <= pmul(w_u[3], w_u[2]);
        end
    end

    // stage R: rotation entries, rounded half away from zero
    localparam logic signed [PW-1:0] One2 = PW'(1) <<< (2 * FRAC_BITS);
    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v);
        logic [PW-1:0] m;
        m = v[PW-1] ? PW'(-v) : PW'(v);
        m = (m + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[PW-1] ? -$signed(m) : $signed(m);
    endfunction
    t_side r_rs;
    logic signed [PW-1:0] r_r [9];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rs <= r_ps;
            r_r[0] <= rnd(One2 - 2 * (r_p[1] + r_p[2]));
            r_r[1] <= rnd(2 * (r_p[3] + r_p[8]));
            r_r[2] <= rnd(2 * (r_p[4] - r_p[7]));
            r_r[3] <= rnd(2 * (r_p[3] - r_p[8]));
            r_r[4] <= rnd(One2 - 2 * (r_p[0] + r_p[2]));
            r_r[5] <= rnd(2 * (r_p[5] + r_p[6]));
            r_r[6] <= rnd(2 * (r_p[4] + r_p[7]));
            r_r[7] <= rnd(2 * (r_p[5] - r_p[6]));
            r_r[8] <= rnd(One2 - 2 * (r_p[0] + r_p[1]));
        end
    end

    // stage M: multiply by scale (entries taken as UW+2 bits signed)
    localparam int unsigned MW = 32 + UW + 2;
    t_side r_ms;
    logic signed [MW-1:0] r_m [9];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ms <= r_rs;
            for (int k = 0; k < 9; k++) begin
                r_m[k] <= MW'($signed(r_r[k][UW+1:0])) *
                          MW'((k < 3) ? r_rs.sx : (k < 6) ? r_rs.sy : r_rs.sz);
            end
        end
    end

    // stage O: round, saturate, output register
    function automatic logic signed [31:0] fin(input logic signed [MW-1:0] v);
        logic [MW-1:0] m;
        logic signed [MW:0] s;
        m = v[MW-1] ? MW'(-v) : MW'(v);
        m = (m + (MW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        s = v[MW-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
        if (s > $signed((MW+1)'(32'h7fffffff))) return 32'h7fffffff;
        if (s < -$signed((MW+1)'(33'h80000000))) return 32'h80000000;
        return 32'(s);
    endfunction
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_data.m00 <= fin(r_m[0]); o_data.m10 <= fin(r_m[1]);
            o_data.m20 <= fin(r_m[2]); o_data.m01 <= fin(r_m[3]);
            o_data.m11 <= fin(r_m[4]); o_data.m21 <= fin(r_m[5]);
            o_data.m02 <= fin(r_m[6]); o_data.m12 <= fin(r_m[7]);
            o_data.m22 <= fin(r_m[8]);
            o_data.m03 <= r_ms.tx; o_data.m13 <= r_ms.ty; o_data.m23 <= r_ms.tz;
        end
    end
    assign o_valid = r_vld[NS-1];

    // a stalled output beat holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output beat changed under stall");
    // pipe advances whenever the output slot frees
    a_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipe stalled with empty output");
endmodule
`default_nettype wire
